// File: rtl/core/letterbox_nearest_scaler_convert_core_assert.svh
// assertion macros for the letterbox scaler core
`ifndef LETTERBOX_NEAREST_SCALER_CONVERT_CORE_ASSERT_SVH
`define LETTERBOX_NEAREST_SCALER_CONVERT_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define LNSC_ASSERT_IMPL(label, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define LNSC_ASSERT_NEXT(label, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error(msg);

`endif

// File: rtl/core/lnsc_pkg.sv
// shared types, constants and color helpers for the letterbox scaler core
package lnsc_pkg;

    localparam int DIM_W     = 13;
    localparam int COORD_W   = 12;
    localparam int PROD_W    = 2 * DIM_W;
    localparam int CFG_IDX_W = 3;
    localparam int FMT_W     = 2;
    localparam int STATUS_W  = 2;
    localparam int COLOR_W   = 16;
    localparam int PIX_W     = 32;
    localparam int MAX_DIM   = 4096;
    localparam int DIV_STEPS = PROD_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // register reset values
    localparam logic [DIM_W-1:0] RST_SCREEN_WIDTH  = DIM_W'(1280);
    localparam logic [DIM_W-1:0] RST_SCREEN_HEIGHT = DIM_W'(720);
    localparam logic [DIM_W-1:0] RST_SOURCE_WIDTH  = DIM_W'(320);
    localparam logic [DIM_W-1:0] RST_SOURCE_HEIGHT = DIM_W'(240);

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SCREEN_WIDTH  = 3'd0,
        REG_SCREEN_HEIGHT = 3'd1,
        REG_SOURCE_WIDTH  = 3'd2,
        REG_SOURCE_HEIGHT = 3'd3,
        REG_PIXEL_FORMAT  = 3'd4
    } cfg_reg_t;

    // pixel formats
    localparam logic [FMT_W-1:0] FMT_RGB565   = 2'd0;
    localparam logic [FMT_W-1:0] FMT_RGBX4444 = 2'd1;
    localparam logic [FMT_W-1:0] FMT_XRGB8888 = 2'd2;
    localparam logic [FMT_W-1:0] FMT_NONE     = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_WRITTEN = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FRAME   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_IGNORED = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_CMP,
        ST_RDIV,
        ST_RECT,
        ST_STEP_GO,
        ST_XDIV,
        ST_YDIV,
        ST_PUSH
    } state_t;

    typedef enum logic [1:0] {
        DIV_RECT,
        DIV_X,
        DIV_Y
    } div_sel_t;

    // controller to datapath
    typedef struct packed {
        logic     mul_load;
        logic     cmp_load;
        logic     rdiv_load;
        logic     rect_load;
        logic     x_load;
        logic     y_load;
        logic     pixel_step;
        logic     frame_push;
        logic     push;
        logic     div_start;
        div_sel_t div_sel;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic prod_differ;
        logic div_done;
        logic steps_dirty;
    } sts_t;

    // one result item
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                write_valid;
        logic [COORD_W-1:0]  dest_x;
        logic [COORD_W-1:0]  dest_y;
        logic [COLOR_W-1:0]  color;
        logic                clear_screen;
        logic [COORD_W-1:0]  next_src_x;
        logic [COORD_W-1:0]  next_src_y;
        logic                frame_last;
    } res_t;

    // dimension clamp to 1..MAX_DIM
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0)
            r = DIM_W'(1);
        else if (32'(v) > 32'(MAX_DIM))
            r = DIM_W'(MAX_DIM);
        else
            r = v;
        return r;
    endfunction

    // source pixel to a1r5g5b5, alpha set
    function automatic logic [COLOR_W-1:0] to_argb1555(input logic [FMT_W-1:0] fmt,
                                                       input logic [PIX_W-1:0] p);
        logic [4:0] r;
        logic [4:0] g;
        logic [4:0] b;
        unique case (fmt)
            FMT_RGB565:
            begin
                r = p[15:11];
                g = p[10:6];
                b = p[4:0];
            end
            FMT_RGBX4444:
            begin
                r = {p[15:12], p[15]};
                g = {p[11:8], p[11]};
                b = {p[7:4], p[7]};
            end
            default:
            begin
                r = p[23:19];
                g = p[15:11];
                b = p[7:3];
            end
        endcase
        return {1'b1, r, g, b};
    endfunction

endpackage

// File: rtl/core/lnsc_div.sv
// restoring divider, one quotient bit per cycle
module lnsc_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [lnsc_pkg::PROD_W-1:0]  dividend,
    input  logic [lnsc_pkg::DIM_W-1:0]   divisor,
    output logic                         done,
    output logic [lnsc_pkg::PROD_W-1:0]  quotient,
    output logic [lnsc_pkg::DIM_W-1:0]   remainder
);
    import lnsc_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIM_W-1:0]     rem_reg;
    logic [PROD_W-1:0]    quo_reg;
    logic [DIM_W-1:0]     dvs_reg;

    logic [DIM_W:0]       shifted;
    logic                 fits;
    logic [DIM_W-1:0]     rem_next;
    logic                 last_step;

    // one trial subtraction
    always_comb
    begin
        shifted  = {rem_reg, quo_reg[PROD_W-1]};
        fits     = shifted >= {1'b0, dvs_reg};
        rem_next = fits ? DIM_W'(shifted - {1'b0, dvs_reg}) : shifted[DIM_W-1:0];
    end

    assign last_step = busy_reg && (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));

    // step control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= last_step;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + DIV_CNT_W'(1);
                if (last_step)
                    busy_reg <= 1'b0;
            end
        end
    end

    // partial remainder and quotient
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[PROD_W-2:0], fits};
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// File: rtl/core/lnsc_datapath.sv
// config registers, rectangle fit, dda walk and color conversion
module lnsc_datapath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [lnsc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lnsc_pkg::DIM_W-1:0]     cfg_data,
    input  logic [lnsc_pkg::PIX_W-1:0]     pixel_value,
    input  lnsc_pkg::cmd_t                 cmd,
    output lnsc_pkg::sts_t                 sts,
    output lnsc_pkg::res_t                 res
);
    import lnsc_pkg::*;

    // configuration
    logic [DIM_W-1:0]   screen_width_reg;
    logic [DIM_W-1:0]   screen_height_reg;
    logic [DIM_W-1:0]   source_width_reg;
    logic [DIM_W-1:0]   source_height_reg;
    logic [FMT_W-1:0]   pixel_format_reg;
    logic               dirty_reg;

    // rectangle state
    logic [COORD_W-1:0] rect_left_reg;
    logic [COORD_W-1:0] rect_top_reg;
    logic [DIM_W-1:0]   rect_width_reg;
    logic [DIM_W-1:0]   rect_height_reg;
    logic [COORD_W-1:0] prev_left_reg;
    logic [COORD_W-1:0] prev_top_reg;
    logic [DIM_W-1:0]   prev_width_reg;
    logic [DIM_W-1:0]   prev_height_reg;
    logic               changed_reg;

    // walk state
    logic [COORD_W-1:0] walk_x_reg;
    logic [COORD_W-1:0] walk_y_reg;
    logic [DIM_W-1:0]   src_x_reg;
    logic [DIM_W-1:0]   src_xrem_reg;
    logic [DIM_W-1:0]   src_y_reg;
    logic [DIM_W-1:0]   src_yrem_reg;
    logic               frame_active_reg;

    // fit scratch and step quotients
    logic [PROD_W-1:0]  lhs_reg;
    logic [PROD_W-1:0]  rhs_reg;
    logic               wide_reg;
    logic [DIM_W-1:0]   dw_reg;
    logic [DIM_W-1:0]   dh_reg;
    logic [DIM_W-1:0]   step_xq_reg;
    logic [DIM_W-1:0]   step_xr_reg;
    logic [DIM_W-1:0]   step_yq_reg;
    logic [DIM_W-1:0]   step_yr_reg;

    logic [DIM_W-1:0]   sw;
    logic [DIM_W-1:0]   sh;
    logic [DIM_W-1:0]   iw;
    logic [DIM_W-1:0]   ih;
    logic               lhs_gt;

    logic               div_done;
    logic [PROD_W-1:0]  div_quo;
    logic [DIM_W-1:0]   div_rem;
    logic [PROD_W-1:0]  div_dividend;
    logic [DIM_W-1:0]   div_divisor;
    logic [DIM_W-1:0]   rw_safe;
    logic [DIM_W-1:0]   rh_safe;

    logic [DIM_W-1:0]   new_width;
    logic [DIM_W-1:0]   new_height;
    logic [COORD_W-1:0] new_left;
    logic [COORD_W-1:0] new_top;
    logic               new_changed;

    logic               ignore;
    logic               x_more;
    logic               y_more;
    logic [DIM_W:0]     sum_x;
    logic [DIM_W:0]     sum_y;
    logic               x_wrap;
    logic               y_wrap;
    logic [DIM_W-1:0]   x_coord_step;
    logic [DIM_W-1:0]   x_rem_step;
    logic [DIM_W-1:0]   y_coord_step;
    logic [DIM_W-1:0]   y_rem_step;

    logic [COORD_W-1:0] walk_x_next;
    logic [COORD_W-1:0] walk_y_next;
    logic [DIM_W-1:0]   src_x_next;
    logic [DIM_W-1:0]   src_xrem_next;
    logic [DIM_W-1:0]   src_y_next;
    logic [DIM_W-1:0]   src_yrem_next;
    logic               frame_active_next;
    logic               last_pixel;

    assign sw     = clamp_dim(screen_width_reg);
    assign sh     = clamp_dim(screen_height_reg);
    assign iw     = clamp_dim(source_width_reg);
    assign ih     = clamp_dim(source_height_reg);
    assign lhs_gt = lhs_reg > rhs_reg;

    assign rw_safe = (rect_width_reg == '0) ? DIM_W'(1) : rect_width_reg;
    assign rh_safe = (rect_height_reg == '0) ? DIM_W'(1) : rect_height_reg;

    // divider operand select
    always_comb
    begin
        case (cmd.div_sel)
            DIV_RECT:
            begin
                div_dividend = lhs_gt ? rhs_reg : lhs_reg;
                div_divisor  = lhs_gt ? ih : iw;
            end
            DIV_X:
            begin
                div_dividend = PROD_W'(iw);
                div_divisor  = rw_safe;
            end
            default:
            begin
                div_dividend = PROD_W'(ih);
                div_divisor  = rh_safe;
            end
        endcase
    end

    lnsc_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign sts.prod_differ = lhs_reg != rhs_reg;
    assign sts.div_done    = div_done;
    assign sts.steps_dirty = dirty_reg;

    // centered rectangle from the fitted size
    always_comb
    begin
        new_width   = (dw_reg == '0) ? DIM_W'(1) : dw_reg;
        new_height  = (dh_reg == '0) ? DIM_W'(1) : dh_reg;
        new_left    = COORD_W'((sw - new_width) >> 1);
        new_top     = COORD_W'((sh - new_height) >> 1);
        new_changed = (new_left != prev_left_reg) || (new_top != prev_top_reg)
                   || (new_width != prev_width_reg) || (new_height != prev_height_reg);
    end

    // dda steps, remainder stays below the rectangle size
    always_comb
    begin
        ignore       = !frame_active_reg || (pixel_format_reg == FMT_NONE);
        x_more       = (DIM_W'(walk_x_reg) + DIM_W'(1)) < rect_width_reg;
        y_more       = (DIM_W'(walk_y_reg) + DIM_W'(1)) < rect_height_reg;
        sum_x        = {1'b0, src_xrem_reg} + {1'b0, step_xr_reg};
        sum_y        = {1'b0, src_yrem_reg} + {1'b0, step_yr_reg};
        x_wrap       = sum_x >= {1'b0, rect_width_reg};
        y_wrap       = sum_y >= {1'b0, rect_height_reg};
        x_rem_step   = x_wrap ? DIM_W'(sum_x - {1'b0, rect_width_reg}) : sum_x[DIM_W-1:0];
        y_rem_step   = y_wrap ? DIM_W'(sum_y - {1'b0, rect_height_reg}) : sum_y[DIM_W-1:0];
        x_coord_step = src_x_reg + step_xq_reg + DIM_W'(x_wrap);
        y_coord_step = src_y_reg + step_yq_reg + DIM_W'(y_wrap);
    end

    // row-major walk
    always_comb
    begin
        walk_x_next       = walk_x_reg;
        walk_y_next       = walk_y_reg;
        src_x_next        = src_x_reg;
        src_xrem_next     = src_xrem_reg;
        src_y_next        = src_y_reg;
        src_yrem_next     = src_yrem_reg;
        frame_active_next = frame_active_reg;
        last_pixel        = 1'b0;
        if (x_more)
        begin
            walk_x_next   = walk_x_reg + COORD_W'(1);
            src_x_next    = x_coord_step;
            src_xrem_next = x_rem_step;
        end
        else
        begin
            walk_x_next   = '0;
            src_x_next    = '0;
            src_xrem_next = '0;
            if (y_more)
            begin
                walk_y_next   = walk_y_reg + COORD_W'(1);
                src_y_next    = y_coord_step;
                src_yrem_next = y_rem_step;
            end
            else
            begin
                walk_y_next       = '0;
                src_y_next        = '0;
                src_yrem_next     = '0;
                frame_active_next = 1'b0;
                last_pixel        = 1'b1;
            end
        end
    end

    // result item
    always_comb
    begin
        res = '0;
        if (cmd.frame_push)
        begin
            res.status       = STATUS_FRAME;
            res.clear_screen = changed_reg;
        end
        else if (ignore)
        begin
            res.status = STATUS_IGNORED;
        end
        else
        begin
            res.status      = STATUS_WRITTEN;
            res.write_valid = 1'b1;
            res.dest_x      = rect_left_reg + walk_x_reg;
            res.dest_y      = rect_top_reg + walk_y_reg;
            res.color       = to_argb1555(pixel_format_reg, pixel_value);
            res.next_src_x  = src_x_next[COORD_W-1:0];
            res.next_src_y  = src_y_next[COORD_W-1:0];
            res.frame_last  = last_pixel;
        end
    end

    // configuration and model state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_width_reg  <= RST_SCREEN_WIDTH;
            screen_height_reg <= RST_SCREEN_HEIGHT;
            source_width_reg  <= RST_SOURCE_WIDTH;
            source_height_reg <= RST_SOURCE_HEIGHT;
            pixel_format_reg  <= FMT_RGB565;
            dirty_reg         <= 1'b0;
            rect_left_reg     <= '0;
            rect_top_reg      <= '0;
            rect_width_reg    <= '0;
            rect_height_reg   <= '0;
            prev_left_reg     <= '0;
            prev_top_reg      <= '0;
            prev_width_reg    <= '0;
            prev_height_reg   <= '0;
            walk_x_reg        <= '0;
            walk_y_reg        <= '0;
            src_x_reg         <= '0;
            src_xrem_reg      <= '0;
            src_y_reg         <= '0;
            src_yrem_reg      <= '0;
            frame_active_reg  <= 1'b0;
        end
        else
        begin
            // a pass that starts now sees the current source sizes
            if (cmd.div_start && (cmd.div_sel == DIV_X))
                dirty_reg <= 1'b0;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_SCREEN_WIDTH:  screen_width_reg  <= cfg_data;
                    REG_SCREEN_HEIGHT: screen_height_reg <= cfg_data;
                    REG_SOURCE_WIDTH:
                    begin
                        source_width_reg <= cfg_data;
                        dirty_reg        <= 1'b1;
                    end
                    REG_SOURCE_HEIGHT:
                    begin
                        source_height_reg <= cfg_data;
                        dirty_reg         <= 1'b1;
                    end
                    REG_PIXEL_FORMAT:  pixel_format_reg  <= cfg_data[FMT_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.rect_load)
            begin
                rect_left_reg    <= new_left;
                rect_top_reg     <= new_top;
                rect_width_reg   <= new_width;
                rect_height_reg  <= new_height;
                prev_left_reg    <= new_left;
                prev_top_reg     <= new_top;
                prev_width_reg   <= new_width;
                prev_height_reg  <= new_height;
                walk_x_reg       <= '0;
                walk_y_reg       <= '0;
                src_x_reg        <= '0;
                src_xrem_reg     <= '0;
                src_y_reg        <= '0;
                src_yrem_reg     <= '0;
                frame_active_reg <= pixel_format_reg != FMT_NONE;
            end
            else if (cmd.pixel_step && !ignore)
            begin
                walk_x_reg       <= walk_x_next;
                walk_y_reg       <= walk_y_next;
                src_x_reg        <= src_x_next;
                src_xrem_reg     <= src_xrem_next;
                src_y_reg        <= src_y_next;
                src_yrem_reg     <= src_yrem_next;
                frame_active_reg <= frame_active_next;
            end
        end
    end

    // fit scratch and step quotients
    always_ff @(posedge clk)
    begin
        if (cmd.mul_load)
        begin
            lhs_reg <= PROD_W'(sw) * PROD_W'(ih);
            rhs_reg <= PROD_W'(sh) * PROD_W'(iw);
        end
        if (cmd.cmp_load)
        begin
            dw_reg   <= sw;
            dh_reg   <= sh;
            wide_reg <= lhs_gt;
        end
        if (cmd.rdiv_load)
        begin
            if (wide_reg)
                dw_reg <= div_quo[DIM_W-1:0];
            else
                dh_reg <= div_quo[DIM_W-1:0];
        end
        if (cmd.rect_load)
            changed_reg <= new_changed;
        if (cmd.x_load)
        begin
            step_xq_reg <= div_quo[DIM_W-1:0];
            step_xr_reg <= div_rem;
        end
        if (cmd.y_load)
        begin
            step_yq_reg <= div_quo[DIM_W-1:0];
            step_yr_reg <= div_rem;
        end
    end

endmodule

// File: rtl/core/lnsc_ctrl.sv
// sequencing of item acceptance, frame fit and step division
module lnsc_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic           mode,
    input  logic           q_full,
    input  lnsc_pkg::sts_t sts,
    output logic           in_stall,
    output lnsc_pkg::cmd_t cmd
);
    import lnsc_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   push_pend_reg;
    logic   push_pend_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            push_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            push_pend_reg <= push_pend_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next     = state_reg;
        push_pend_next = push_pend_reg;
        in_stall       = 1'b1;
        cmd            = '0;
        cmd.div_sel    = DIV_RECT;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (sts.steps_dirty)
                begin
                    state_next = ST_STEP_GO;
                end
                else
                begin
                    in_stall = q_full;
                    if (in_valid && !q_full)
                    begin
                        if (mode)
                        begin
                            cmd.pixel_step = 1'b1;
                            cmd.push       = 1'b1;
                        end
                        else
                        begin
                            push_pend_next = 1'b1;
                            state_next     = ST_MUL;
                        end
                    end
                end
            end
            ST_MUL:
            begin
                cmd.mul_load = 1'b1;
                state_next   = ST_CMP;
            end
            ST_CMP:
            begin
                cmd.cmp_load = 1'b1;
                if (sts.prod_differ)
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_RECT;
                    state_next    = ST_RDIV;
                end
                else
                begin
                    state_next = ST_RECT;
                end
            end
            ST_RDIV:
            begin
                if (sts.div_done)
                begin
                    cmd.rdiv_load = 1'b1;
                    state_next    = ST_RECT;
                end
            end
            ST_RECT:
            begin
                cmd.rect_load = 1'b1;
                state_next    = ST_STEP_GO;
            end
            ST_STEP_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_X;
                state_next    = ST_XDIV;
            end
            ST_XDIV:
            begin
                if (sts.div_done)
                begin
                    cmd.x_load    = 1'b1;
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_Y;
                    state_next    = ST_YDIV;
                end
            end
            ST_YDIV:
            begin
                cmd.div_sel = DIV_Y;
                if (sts.div_done)
                begin
                    cmd.y_load = 1'b1;
                    state_next = push_pend_reg ? ST_PUSH : ST_IDLE;
                end
            end
            ST_PUSH:
            begin
                if (!q_full)
                begin
                    cmd.push       = 1'b1;
                    cmd.frame_push = 1'b1;
                    push_pend_next = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/core/lnsc_out_queue.sv
// two-entry result queue between the core and the output channel
module lnsc_out_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  lnsc_pkg::res_t push_res,
    input  logic           out_stall,
    output logic           out_valid,
    output lnsc_pkg::res_t out_res,
    output logic           full
);
    import lnsc_pkg::*;

    res_t       entry_reg [2];
    logic       head_reg;
    logic [1:0] count_reg;
    logic       tail;
    logic       pop;

    assign tail      = head_reg ^ count_reg[0];
    assign out_valid = count_reg != 2'd0;
    assign pop       = out_valid && !out_stall;
    assign full      = count_reg == 2'd2;
    assign out_res   = entry_reg[head_reg];

    // occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (pop)
                head_reg <= ~head_reg;
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

    // item storage
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[tail] <= push_res;
    end

endmodule

// File: rtl/core/letterbox_nearest_scaler_convert_core.sv
// top level of the letterbox nearest-neighbor scaler and color converter
// A pixel item (mode 1) is taken and its result queued in the same cycle; the
// result appears on the output in the next cycle. Pixel items stream at one
// per cycle while the output side keeps up, and a two-entry result queue lets
// one more item in while a result waits. A frame-start item (mode 0) holds the
// input off through one multiply, a compare, then up to three passes of the
// shared 26-step restoring divider (rectangle size, column step, row step), and
// the queuing of the result; when the two products match the size pass is
// skipped. A full result queue delays that last step in either case. Writing
// source_width or source_height recomputes the two step quotients on that
// divider, during which no item is taken, and a write during that pass starts
// another. Dimension registers are clamped to 1..MAX_DIM when used.
`include "letterbox_nearest_scaler_convert_core_assert.svh"

module letterbox_nearest_scaler_convert_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [lnsc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lnsc_pkg::DIM_W-1:0]      cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            mode,
    input  logic [lnsc_pkg::PIX_W-1:0]      pixel_value,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [lnsc_pkg::STATUS_W-1:0]   status,
    output logic                            write_valid,
    output logic [lnsc_pkg::COORD_W-1:0]    dest_x,
    output logic [lnsc_pkg::COORD_W-1:0]    dest_y,
    output logic [lnsc_pkg::COLOR_W-1:0]    color,
    output logic                            clear_screen,
    output logic [lnsc_pkg::COORD_W-1:0]    next_src_x,
    output logic [lnsc_pkg::COORD_W-1:0]    next_src_y,
    output logic                            frame_last
);
    import lnsc_pkg::*;

    cmd_t cmd;
    sts_t sts;
    res_t core_res;
    res_t head_res;
    logic q_full;

    lnsc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .mode     (mode),
        .q_full   (q_full),
        .sts      (sts),
        .in_stall (in_stall),
        .cmd      (cmd)
    );

    lnsc_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .pixel_value (pixel_value),
        .cmd         (cmd),
        .sts         (sts),
        .res         (core_res)
    );

    lnsc_out_queue u_out_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd.push),
        .push_res  (core_res),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_res   (head_res),
        .full      (q_full)
    );

    // output fields from the queue head
    assign status       = head_res.status;
    assign write_valid  = head_res.write_valid;
    assign dest_x       = head_res.dest_x;
    assign dest_y       = head_res.dest_y;
    assign color        = head_res.color;
    assign clear_screen = head_res.clear_screen;
    assign next_src_x   = head_res.next_src_x;
    assign next_src_y   = head_res.next_src_y;
    assign frame_last   = head_res.frame_last;

    // checks
    `LNSC_ASSERT_NEXT(a_pixel_result_queued, in_valid && !in_stall && mode, out_valid,
        "pixel item accepted but no result queued")
    `LNSC_ASSERT_NEXT(a_frame_start_busy, in_valid && !in_stall && !mode, in_stall,
        "frame start accepted but input not held off")
    `LNSC_ASSERT_IMPL(a_write_matches_status, out_valid,
        write_valid == (status == STATUS_WRITTEN), "write_valid disagrees with status")
    `LNSC_ASSERT_IMPL(a_last_pixel_wraps, out_valid && frame_last,
        write_valid && next_src_x == '0 && next_src_y == '0,
        "last pixel without wrapped source coordinate")

endmodule

// File: dv/letterbox_nearest_scaler_convert_core_tb.sv
// testbench for the letterbox nearest-neighbor scaler and color converter core
`timescale 1ns / 100ps

module letterbox_nearest_scaler_convert_core_tb;

    import lnsc_pkg::*;

    localparam int QUIET_LIMIT = 4000;
    localparam int WIDE_ROW_PIXELS = 256;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DIM_W-1:0]     cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic                 mode = 1'b0;
    logic [PIX_W-1:0]     pixel_value = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [STATUS_W-1:0]  status;
    logic                 write_valid;
    logic [COORD_W-1:0]   dest_x;
    logic [COORD_W-1:0]   dest_y;
    logic [COLOR_W-1:0]   color;
    logic                 clear_screen;
    logic [COORD_W-1:0]   next_src_x;
    logic [COORD_W-1:0]   next_src_y;
    logic                 frame_last;

    // predictor copy of the registers
    logic [DIM_W-1:0] cfg_scr_w = RST_SCREEN_WIDTH;
    logic [DIM_W-1:0] cfg_scr_h = RST_SCREEN_HEIGHT;
    logic [DIM_W-1:0] cfg_src_w = RST_SOURCE_WIDTH;
    logic [DIM_W-1:0] cfg_src_h = RST_SOURCE_HEIGHT;
    logic [FMT_W-1:0] cfg_fmt = FMT_RGB565;

    // predictor copy of the fit rectangle and the walk
    logic [COORD_W-1:0] fit_left = '0;
    logic [COORD_W-1:0] fit_top = '0;
    logic [DIM_W-1:0]   fit_w = '0;
    logic [DIM_W-1:0]   fit_h = '0;
    logic [COORD_W-1:0] last_left = '0;
    logic [COORD_W-1:0] last_top = '0;
    logic [DIM_W-1:0]   last_w = '0;
    logic [DIM_W-1:0]   last_h = '0;
    logic [COORD_W-1:0] col_idx = '0;
    logic [COORD_W-1:0] row_idx = '0;
    logic [2*DIM_W-1:0] col_acc = '0;
    logic [2*DIM_W-1:0] row_acc = '0;
    logic               drawing = 1'b0;

    res_t expected_results[$];
    int   mismatches = 0;
    int   items_sent = 0;
    int   quiet_cycles = 0;
    int   send_gap_pct = 0;
    int   recv_stall_pct = 0;

    letterbox_nearest_scaler_convert_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .mode         (mode),
        .pixel_value  (pixel_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .write_valid  (write_valid),
        .dest_x       (dest_x),
        .dest_y       (dest_y),
        .color        (color),
        .clear_screen (clear_screen),
        .next_src_x   (next_src_x),
        .next_src_y   (next_src_y),
        .frame_last   (frame_last)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // dimension registers are used as 1..MAX_DIM
    function automatic int unsigned dim_used(input logic [DIM_W-1:0] v);
        if (v == '0)
            return 1;
        if (int'(v) > MAX_DIM)
            return MAX_DIM;
        return 32'(v);
    endfunction

    // widen each channel to 8 bits, then keep the top 5
    function automatic logic [COLOR_W-1:0] color_1555(input logic [FMT_W-1:0] fmt,
                                                      input logic [PIX_W-1:0] p);
        logic [7:0] r8;
        logic [7:0] g8;
        logic [7:0] b8;
        if (fmt == FMT_RGB565)
        begin
            r8 = {p[15:11], p[15:13]};
            g8 = {p[10:5], p[10:9]};
            b8 = {p[4:0], p[4:2]};
        end
        else if (fmt == FMT_RGBX4444)
        begin
            r8 = {p[15:12], p[15:12]};
            g8 = {p[11:8], p[11:8]};
            b8 = {p[7:4], p[7:4]};
        end
        else
        begin
            r8 = p[23:16];
            g8 = p[15:8];
            b8 = p[7:0];
        end
        return {1'b1, r8[7:3], g8[7:3], b8[7:3]};
    endfunction

    // exact quotient/remainder step: coordinate in the top 13 bits
    function automatic logic [2*DIM_W-1:0] dda_advance(input logic [2*DIM_W-1:0] acc,
                                                       input int unsigned stepv,
                                                       input int unsigned divv);
        int unsigned coord;
        int unsigned rem;
        int unsigned sum;
        coord = 32'(acc[2*DIM_W-1:DIM_W]);
        rem = 32'(acc[DIM_W-1:0]);
        if (divv == 0)
            divv = 1;
        sum = rem + stepv;
        coord = (coord + sum / divv) & 32'h1fff;
        rem = (sum % divv) & 32'h1fff;
        return {coord[DIM_W-1:0], rem[DIM_W-1:0]};
    endfunction

    // expected result of one accepted item, advancing the predictor state
    function automatic res_t predict_result(input logic m, input logic [PIX_W-1:0] pv);
        res_t r;
        int unsigned sw;
        int unsigned sh;
        int unsigned iw;
        int unsigned ih;
        int unsigned dw;
        int unsigned dh;
        int unsigned lhs;
        int unsigned rhs;
        r = '0;
        if (m == 1'b0)
        begin
            sw = dim_used(cfg_scr_w);
            sh = dim_used(cfg_scr_h);
            iw = dim_used(cfg_src_w);
            ih = dim_used(cfg_src_h);
            lhs = sw * ih;
            rhs = sh * iw;
            dw = sw;
            dh = sh;
            if (lhs > rhs)
                dw = (sh * iw) / ih;
            else if (lhs < rhs)
                dh = (sw * ih) / iw;
            if (dw == 0)
                dw = 1;
            if (dh == 0)
                dh = 1;
            fit_w = DIM_W'(dw);
            fit_h = DIM_W'(dh);
            fit_left = COORD_W'((sw - dw) / 2);
            fit_top = COORD_W'((sh - dh) / 2);
            r.status = STATUS_FRAME;
            r.clear_screen = (fit_left != last_left) || (fit_top != last_top)
                          || (fit_w != last_w) || (fit_h != last_h);
            last_left = fit_left;
            last_top = fit_top;
            last_w = fit_w;
            last_h = fit_h;
            col_idx = '0;
            row_idx = '0;
            col_acc = '0;
            row_acc = '0;
            drawing = (cfg_fmt != FMT_NONE);
            return r;
        end
        if (!drawing || cfg_fmt == FMT_NONE)
        begin
            r.status = STATUS_IGNORED;
            return r;
        end
        r.status = STATUS_WRITTEN;
        r.write_valid = 1'b1;
        r.dest_x = fit_left + col_idx;
        r.dest_y = fit_top + row_idx;
        r.color = color_1555(cfg_fmt, pv);
        // row-major walk over the rectangle
        if (int'(col_idx) + 1 < int'(fit_w))
        begin
            col_idx = col_idx + COORD_W'(1);
            col_acc = dda_advance(col_acc, dim_used(cfg_src_w), 32'(fit_w));
        end
        else
        begin
            col_idx = '0;
            col_acc = '0;
            if (int'(row_idx) + 1 < int'(fit_h))
            begin
                row_idx = row_idx + COORD_W'(1);
                row_acc = dda_advance(row_acc, dim_used(cfg_src_h), 32'(fit_h));
            end
            else
            begin
                row_idx = '0;
                row_acc = '0;
                drawing = 1'b0;
                r.frame_last = 1'b1;
            end
        end
        r.next_src_x = col_acc[DIM_W+COORD_W-1:DIM_W];
        r.next_src_y = row_acc[DIM_W+COORD_W-1:DIM_W];
        return r;
    endfunction

    function automatic string res_text(input res_t r);
        return $sformatf("status=%0d wr=%0b x=%0d y=%0d color=%h clr=%0b nx=%0d ny=%0d last=%0b",
                         r.status, r.write_valid, r.dest_x, r.dest_y, r.color,
                         r.clear_screen, r.next_src_x, r.next_src_y, r.frame_last);
    endfunction

    task automatic report_mismatch(input string what, input res_t want, input res_t got);
        mismatches++;
        if (mismatches <= 10)
        begin
            $display("mismatch (%s) at %0t", what, $time);
            $display("  expected %s", res_text(want));
            $display("  actual   %s", res_text(got));
        end
    endtask

    // receiver stall
    always @(negedge clk)
    begin
        out_stall <= (recv_stall_pct != 0) && ($urandom_range(0, 99) < recv_stall_pct);
    end

    // compare each result with the oldest expectation
    always @(posedge clk)
    begin : result_check
        res_t got;
        res_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got.status = status;
            got.write_valid = write_valid;
            got.dest_x = dest_x;
            got.dest_y = dest_y;
            got.color = color;
            got.clear_screen = clear_screen;
            got.next_src_x = next_src_x;
            got.next_src_y = next_src_y;
            got.frame_last = frame_last;
            if (expected_results.size() == 0)
                report_mismatch("no item pending", '0, got);
            else
            begin
                want = expected_results.pop_front();
                if (got !== want)
                    report_mismatch("wrong field", want, got);
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write)
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // send one item, with random idle cycles ahead of it
    task automatic send_item(input logic m, input logic [PIX_W-1:0] pv);
        if (send_gap_pct != 0 && $urandom_range(0, 99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            mode <= 1'($urandom());
            pixel_value <= $urandom();
            @(negedge clk);
            while ($urandom_range(0, 99) < send_gap_pct)
                @(negedge clk);
        end
        in_valid <= 1'b1;
        mode <= m;
        pixel_value <= pv;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_results.push_back(predict_result(m, pv));
        items_sent++;
        @(negedge clk);
    endtask

    // let every pending result drain before touching the registers
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [DIM_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        case (idx)
            REG_SCREEN_WIDTH:  cfg_scr_w = val;
            REG_SCREEN_HEIGHT: cfg_scr_h = val;
            REG_SOURCE_WIDTH:  cfg_src_w = val;
            REG_SOURCE_HEIGHT: cfg_src_h = val;
            REG_PIXEL_FORMAT:  cfg_fmt = val[FMT_W-1:0];
            default:           ;
        endcase
        @(negedge clk);
        cfg_write <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_geometry(input logic [DIM_W-1:0] sw, input logic [DIM_W-1:0] sh,
                                input logic [DIM_W-1:0] iw, input logic [DIM_W-1:0] ih,
                                input logic [DIM_W-1:0] fmt_word);
        wait_idle();
        write_reg(REG_SCREEN_WIDTH, sw);
        write_reg(REG_SCREEN_HEIGHT, sh);
        write_reg(REG_SOURCE_WIDTH, iw);
        write_reg(REG_SOURCE_HEIGHT, ih);
        write_reg(REG_PIXEL_FORMAT, fmt_word);
    endtask

    // mostly small sizes, now and then an extreme or out-of-range one
    function automatic logic [DIM_W-1:0] pick_dim();
        if ($urandom_range(0, 99) >= 8)
            return DIM_W'($urandom_range(1, 16));
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return DIM_W'(MAX_DIM);
            2:       return '1;
            default: return DIM_W'($urandom());
        endcase
    endfunction

    // format in the low bits, random upper bits
    function automatic logic [DIM_W-1:0] pick_format_word(input bit allow_none);
        logic [DIM_W-1:0] w;
        w = DIM_W'($urandom());
        if (allow_none && $urandom_range(0, 9) == 0)
            w[FMT_W-1:0] = FMT_NONE;
        else
            w[FMT_W-1:0] = FMT_W'($urandom_range(0, 2));
        return w;
    endfunction

    // source size or format change in the middle of a frame
    task automatic mid_frame_change();
        wait_idle();
        if ($urandom_range(0, 1) == 0)
        begin
            write_reg(REG_SOURCE_WIDTH, pick_dim());
            if ($urandom_range(0, 1) == 0)
                write_reg(REG_SOURCE_HEIGHT, pick_dim());
        end
        else
        begin
            write_reg(REG_PIXEL_FORMAT, {(DIM_W-FMT_W)'($urandom()), FMT_NONE});
            repeat ($urandom_range(1, 2)) send_item(1'b1, $urandom());
            wait_idle();
            write_reg(REG_PIXEL_FORMAT, pick_format_word(1'b0));
        end
    endtask

    // pixel before any frame, default fit, restarts, every format, format 3 cases
    task automatic test_directed_basics();
        send_item(1'b1, 32'h1234_5678);
        send_item(1'b0, 32'h0000_0000);
        send_item(1'b0, 32'hffff_ffff);
        send_item(1'b1, 32'h0000_0000);
        send_item(1'b1, 32'h0000_ffff);
        send_item(1'b1, 32'hffff_0000);
        send_item(1'b1, 32'h0000_5aa5);
        wait_idle();
        write_reg(REG_PIXEL_FORMAT, DIM_W'(FMT_RGBX4444));
        send_item(1'b1, 32'h0000_f0f0);
        send_item(1'b1, 32'hffff_0f0f);
        wait_idle();
        write_reg(REG_PIXEL_FORMAT, DIM_W'(FMT_XRGB8888));
        send_item(1'b1, 32'h00ff_ffff);
        send_item(1'b1, 32'hff00_0000);
        wait_idle();
        write_reg(REG_PIXEL_FORMAT, DIM_W'(FMT_NONE));
        send_item(1'b1, 32'h00ff_00ff);
        wait_idle();
        write_reg(REG_PIXEL_FORMAT, DIM_W'(FMT_RGB565));
        send_item(1'b1, 32'h0000_8421);
        wait_idle();
        write_reg(REG_PIXEL_FORMAT, DIM_W'(FMT_NONE));
        send_item(1'b0, 32'h0000_0000);
        send_item(1'b1, 32'h0000_ffff);
    endtask

    // whole small frame to its last pixel, then clamped register values
    task automatic test_frame_completion();
        set_geometry(13'd3, 13'd2, 13'd3, 13'd2, {11'h7ff, FMT_RGB565});
        send_item(1'b0, 32'h0);
        repeat (6) send_item(1'b1, $urandom());
        send_item(1'b1, $urandom());
        // zero and oversize registers; shrunk height rounds to zero
        set_geometry(13'd0, 13'h1fff, 13'h1fff, 13'd1, DIM_W'(FMT_XRGB8888));
        send_item(1'b0, 32'h0);
        send_item(1'b1, $urandom());
    endtask

    // start of a full-width row on the widest rectangle, broken off
    task automatic test_wide_row();
        set_geometry(DIM_W'(MAX_DIM), DIM_W'(MAX_DIM), DIM_W'(MAX_DIM), 13'd1,
                     pick_format_word(1'b0));
        send_item(1'b0, $urandom());
        repeat (WIDE_ROW_PIXELS) send_item(1'b1, $urandom());
    endtask

    // random geometry, then a frame of random pixels, sometimes broken off
    task automatic run_random_frame();
        int unsigned area;
        int unsigned budget;
        set_geometry(pick_dim(), pick_dim(), pick_dim(), pick_dim(), pick_format_word(1'b1));
        send_item(1'b0, $urandom());
        area = 32'(fit_w) * 32'(fit_h);
        budget = (area <= 300) ? area : $urandom_range(1, 40);
        if ($urandom_range(0, 9) == 0)
            budget = $urandom_range(1, budget);
        if (!drawing)
            repeat ($urandom_range(1, 2)) send_item(1'b1, $urandom());
        while (drawing && budget != 0)
        begin
            if ($urandom_range(0, 99) < 2)
                mid_frame_change();
            send_item(1'b1, $urandom());
            budget--;
        end
        // stray items of either mode
        if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 4)) send_item(1'($urandom_range(0, 1)), $urandom());
    endtask

    task automatic test_random_frames(input int count);
        int stop_at;
        stop_at = items_sent + count;
        while (items_sent < stop_at)
            run_random_frame();
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        send_gap_pct = 21;
        recv_stall_pct = 80;
        test_directed_basics();
        test_frame_completion();
        test_random_frames(440);
        send_gap_pct = 80;
        recv_stall_pct = 21;
        test_random_frames(440);
        send_gap_pct = 0;
        recv_stall_pct = 0;
        test_wide_row();
        test_random_frames(440);
        wait_idle();
        repeat (16) @(negedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
